@@ hdl/impq_pkg.sv @@
// impq_pkg: shared types and constants for the indexed max priority queue.
// No dependencies.
`default_nettype none
package impq_pkg;
    localparam int CAPACITY = 64;
    localparam int ID_W     = 6;
    localparam int CNT_W    = 7;
    localparam int PRIO_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_RAISE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOWER  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [ST_W-1:0] ST_DIR     = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ID_W-1:0]          elem_id;
        logic signed [PRIO_W-1:0] priority_req;
    } impq_req_t;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [ID_W-1:0]          out_id;
        logic signed [PRIO_W-1:0] out_priority;
        logic [CNT_W-1:0]         count;
    } impq_res_t;
endpackage
`default_nettype wire

@@ hdl/indexed_max_priority_queue.sv @@
// Refused ops and unused codes go straight to the result; query and direction refusals
// pass through S_CHK; insert at the root and removal of the last element do no sift; each
// sift-up compare steps S_SUP, S_SUP1, S_SUP2 and each sift-down level S_SDN to S_SD3.
// One transaction in flight; the next is taken the cycle after the result is registered.
// Reset (sync, active low) empties the heap, sets max_elements to 64, leaves memories as is.
// Top level: stream ports, config register, output register. Uses impq_pkg, impq_core.
`default_nettype none
module indexed_max_priority_queue (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire [6:0]   cfg_wr_data,   // max_elements
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [39:0]  s_tdata,       // elem_id[5:0], priority_req[37:6], zero pad
    input  wire [2:0]   s_tuser,       // operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,       // out_id[5:0], out_priority[37:6], count[44:38]
    output logic [2:0]  m_tuser        // status
);
    import impq_pkg::*;

    logic [CNT_W-1:0] max_el_reg;
    logic m_tvalid_reg;
    impq_res_t m_res_reg;
    impq_req_t req;
    impq_res_t res;
    logic res_valid, res_ready, req_ready;

    assign req.operation = s_tuser;
    assign req.elem_id = s_tdata[5:0];
    assign req.priority_req = s_tdata[37:6];
    assign res_ready = !m_tvalid_reg || m_tready;
    assign s_tready = req_ready;

    impq_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (req_ready),
        .req          (req),
        .max_elements (max_el_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_el_reg <= 7'd64;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_el_reg <= cfg_wr_data;
            end
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser = m_res_reg.status;
    assign m_tdata = {3'b000, m_res_reg.count, m_res_reg.out_priority, m_res_reg.out_id};
endmodule
`default_nettype wire

@@ hdl/impq_core.sv @@
// impq_core: heap sequencer over synchronous slot, priority and position memories.
// Depends on impq_pkg.
`default_nettype none
module impq_core (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      req_valid,
    output logic                     req_ready,
    input  impq_pkg::impq_req_t      req,
    input  wire [impq_pkg::CNT_W-1:0] max_elements,
    output logic                     res_valid,
    input  wire                      res_ready,
    output impq_pkg::impq_res_t      res
);
    import impq_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_RM1  = 4'd2;
    localparam logic [3:0] S_RM2  = 4'd3;
    localparam logic [3:0] S_RM3  = 4'd4;
    localparam logic [3:0] S_SUP  = 4'd5;
    localparam logic [3:0] S_SUP1 = 4'd6;
    localparam logic [3:0] S_SUP2 = 4'd7;
    localparam logic [3:0] S_SDN  = 4'd8;
    localparam logic [3:0] S_SD1  = 4'd9;
    localparam logic [3:0] S_SD2  = 4'd10;
    localparam logic [3:0] S_SD3  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [CAPACITY-1:0] present_reg, present_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic signed [PRIO_W-1:0] req_reg, req_next;
    logic [ID_W-1:0] pos_reg, pos_next;
    logic [ID_W-1:0] myid_reg, myid_next;
    logic signed [PRIO_W-1:0] myp_reg, myp_next;
    logic [ID_W-1:0] lid_reg, lid_next, rid_reg, rid_next, top_reg, top_next;
    logic signed [PRIO_W-1:0] lp_reg, lp_next;
    logic [ST_W-1:0] st_reg, st_next;
    logic [ID_W-1:0] oid_reg, oid_next;
    logic signed [PRIO_W-1:0] oprio_reg, oprio_next;

    logic [ID_W-1:0] hs_mem [CAPACITY];
    logic signed [PRIO_W-1:0] pr_mem [CAPACITY];
    logic [ID_W-1:0] pb_mem [CAPACITY];
    logic [ID_W-1:0] hs_q, pb_q;
    logic signed [PRIO_W-1:0] pr_q;
    logic hs_we, pr_we, pb_we;
    logic [ID_W-1:0] hs_waddr, hs_wdata, hs_raddr, pr_waddr, pr_raddr;
    logic [ID_W-1:0] pb_waddr, pb_wdata, pb_raddr;
    logic signed [PRIO_W-1:0] pr_wdata;

    logic [CNT_W-1:0] lpos;
    logic [CNT_W:0] rpos;
    logic l_ok, r_ok, sel_l, sel_r, in_range;
    logic signed [PRIO_W-1:0] best_p;

    always_ff @(posedge aclk) begin
        if (hs_we) begin
            hs_mem[hs_waddr] <= hs_wdata;
        end
        hs_q <= hs_mem[hs_raddr];
        if (pr_we) begin
            pr_mem[pr_waddr] <= pr_wdata;
        end
        pr_q <= pr_mem[pr_raddr];
        if (pb_we) begin
            pb_mem[pb_waddr] <= pb_wdata;
        end
        pb_q <= pb_mem[pb_raddr];
    end

    assign lpos = {pos_reg, 1'b1};
    assign rpos = {1'b0, pos_reg, 1'b0} + 8'd2;
    assign l_ok = lpos < cnt_reg;
    assign r_ok = rpos < {1'b0, cnt_reg};
    assign sel_l = lp_reg > myp_reg;
    assign best_p = sel_l ? lp_reg : myp_reg;
    assign sel_r = r_ok && (pr_q > best_p);
    assign in_range = {1'b0, req.elem_id} < max_elements;

    always_comb begin
        state_next = state_reg;
        present_next = present_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        id_next = id_reg;
        req_next = req_reg;
        pos_next = pos_reg;
        myid_next = myid_reg;
        myp_next = myp_reg;
        lid_next = lid_reg;
        rid_next = rid_reg;
        top_next = top_reg;
        lp_next = lp_reg;
        st_next = st_reg;
        oid_next = oid_reg;
        oprio_next = oprio_reg;
        hs_we = 1'b0;
        pr_we = 1'b0;
        pb_we = 1'b0;
        hs_waddr = pos_reg;
        hs_wdata = myid_reg;
        pb_waddr = myid_reg;
        pb_wdata = pos_reg;
        pr_waddr = id_reg;
        pr_wdata = req_reg;
        hs_raddr = '0;
        pr_raddr = '0;
        pb_raddr = req.elem_id;
        req_ready = (state_reg == S_IDLE);
        res_valid = (state_reg == S_DONE);

        unique case (state_reg)
            S_IDLE: begin
                pr_raddr = req.elem_id;
                if (req_valid) begin
                    op_next = req.operation;
                    id_next = req.elem_id;
                    req_next = req.priority_req;
                    st_next = ST_OK;
                    oid_next = '0;
                    oprio_next = '0;
                    state_next = S_DONE;
                    priority if (req.operation == OP_REMOVE) begin
                        if (cnt_reg == '0) begin
                            st_next = ST_EMPTY;
                        end else begin
                            state_next = S_RM1;
                        end
                    end else if (req.operation == OP_INSERT || req.operation == OP_RAISE
                                 || req.operation == OP_LOWER
                                 || req.operation == OP_QUERY) begin
                        priority if (!in_range) begin
                            st_next = ST_RANGE;
                        end else if (req.operation == OP_INSERT) begin
                            if (present_reg[req.elem_id] || cnt_reg >= CNT_W'(CAPACITY)) begin
                                st_next = ST_PRESENT;
                            end else begin
                                present_next[req.elem_id] = 1'b1;
                                pr_we = 1'b1;
                                pr_waddr = req.elem_id;
                                pr_wdata = req.priority_req;
                                pos_next = cnt_reg[ID_W-1:0];
                                cnt_next = cnt_reg + 7'd1;
                                myid_next = req.elem_id;
                                myp_next = req.priority_req;
                                state_next = S_SUP;
                            end
                        end else if (!present_reg[req.elem_id]) begin
                            st_next = ST_ABSENT;
                        end else begin
                            state_next = S_CHK;
                        end
                    end else begin
                        st_next = ST_OK;
                    end
                end
            end
            S_CHK: begin
                myid_next = id_reg;
                myp_next = req_reg;
                pos_next = pb_q;
                state_next = S_DONE;
                priority if (op_reg == OP_QUERY) begin
                    oprio_next = pr_q;
                end else if (op_reg == OP_RAISE) begin
                    if (pr_q >= req_reg) begin
                        st_next = ST_DIR;
                    end else begin
                        pr_we = 1'b1;
                        state_next = S_SUP;
                    end
                end else begin
                    if (pr_q <= req_reg) begin
                        st_next = ST_DIR;
                    end else begin
                        pr_we = 1'b1;
                        state_next = S_SDN;
                    end
                end
            end
            S_RM1: begin
                top_next = hs_q;
                pr_raddr = hs_q;
                hs_raddr = ID_W'(cnt_reg - 7'd1);
                state_next = S_RM2;
            end
            S_RM2: begin
                oid_next = top_reg;
                oprio_next = pr_q;
                present_next[top_reg] = 1'b0;
                cnt_next = cnt_reg - 7'd1;
                myid_next = hs_q;
                pr_raddr = hs_q;
                pos_next = '0;
                state_next = (cnt_reg == 7'd1) ? S_DONE : S_RM3;
            end
            S_RM3: begin
                myp_next = pr_q;
                state_next = S_SDN;
            end
            S_SUP: begin
                hs_raddr = ID_W'(pos_reg - 6'd1) >> 1;
                state_next = (pos_reg == '0) ? S_FIN : S_SUP1;
            end
            S_SUP1: begin
                lid_next = hs_q;
                pr_raddr = hs_q;
                state_next = S_SUP2;
            end
            S_SUP2: begin
                if (pr_q < myp_reg) begin
                    hs_we = 1'b1;
                    hs_wdata = lid_reg;
                    pb_we = 1'b1;
                    pb_waddr = lid_reg;
                    pos_next = ID_W'(pos_reg - 6'd1) >> 1;
                    state_next = S_SUP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_SDN: begin
                hs_raddr = lpos[ID_W-1:0];
                state_next = l_ok ? S_SD1 : S_FIN;
            end
            S_SD1: begin
                lid_next = hs_q;
                pr_raddr = hs_q;
                hs_raddr = rpos[ID_W-1:0];
                state_next = S_SD2;
            end
            S_SD2: begin
                lp_next = pr_q;
                rid_next = hs_q;
                pr_raddr = hs_q;
                state_next = S_SD3;
            end
            S_SD3: begin
                priority if (sel_r) begin
                    hs_we = 1'b1;
                    hs_wdata = rid_reg;
                    pb_we = 1'b1;
                    pb_waddr = rid_reg;
                    pos_next = rpos[ID_W-1:0];
                    state_next = S_SDN;
                end else if (sel_l) begin
                    hs_we = 1'b1;
                    hs_wdata = lid_reg;
                    pb_we = 1'b1;
                    pb_waddr = lid_reg;
                    pos_next = lpos[ID_W-1:0];
                    state_next = S_SDN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                hs_we = 1'b1;
                pb_we = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            present_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            present_reg <= present_next;
            cnt_reg <= cnt_next;
        end
        op_reg <= op_next;
        id_reg <= id_next;
        req_reg <= req_next;
        pos_reg <= pos_next;
        myid_reg <= myid_next;
        myp_reg <= myp_next;
        lid_reg <= lid_next;
        rid_reg <= rid_next;
        top_reg <= top_next;
        lp_reg <= lp_next;
        st_reg <= st_next;
        oid_reg <= oid_next;
        oprio_reg <= oprio_next;
    end

    assign res.status = st_reg;
    assign res.out_id = oid_reg;
    assign res.out_priority = oprio_reg;
    assign res.count = cnt_reg;
endmodule
`default_nettype wire

@@ hdl/impq_checker.sv @@
// impq_checker: port-level assertions for the priority queue, bound to the top level.
// Depends on impq_pkg and the top level's ports.
`default_nettype none
module impq_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire [2:0]  m_tuser
);
    import impq_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[44:38] <= CNT_W'(CAPACITY))
        else $error("count above capacity");
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[37:0] == 38'd0)
        else $error("refused transaction carries data");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[44:38] == 7'd0)
        else $error("empty status with nonzero count");
endmodule

bind indexed_max_priority_queue impq_checker u_impq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ bench/indexed_max_priority_queue_check.sv @@
// Checker for indexed_max_priority_queue: watches both stream channels, predicts each
// result with an indexed max-heap of its own and compares the whole result struct.
// Depends on impq_pkg.
`timescale 1ns / 1ps
module indexed_max_priority_queue_check (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_wr_en,
    input  wire [6:0]  cfg_wr_data,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [39:0] s_tdata,
    input  wire [2:0]  s_tuser,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [47:0] m_tdata,
    input  wire [2:0]  m_tuser,
    output int         fail_count,
    output int         pending,
    output int         result_total
);
    import impq_pkg::*;

    logic [ID_W-1:0]          slot_ids [CAPACITY];
    logic signed [PRIO_W-1:0] prio_of [CAPACITY];
    int                       pos_of [CAPACITY];
    bit                       held [CAPACITY];
    int                       heap_size;
    logic [6:0]               id_limit;
    impq_res_t                awaited [$];

    function automatic logic signed [PRIO_W-1:0] slot_prio(int p);
        return prio_of[slot_ids[p]];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [ID_W-1:0] ia, ib;
        ia = slot_ids[a];
        ib = slot_ids[b];
        slot_ids[a] = ib;
        slot_ids[b] = ia;
        pos_of[ib] = a;
        pos_of[ia] = b;
    endfunction

    function automatic void bubble_up(int p);
        int par;
        while (p > 0) begin
            par = (p - 1) / 2;
            if (slot_prio(p) <= slot_prio(par)) break;
            swap_slots(p, par);
            p = par;
        end
    endfunction

    function automatic void bubble_down(int p);
        int l, r, big;
        forever begin
            l = 2 * p + 1;
            r = 2 * p + 2;
            big = p;
            if (l < heap_size && slot_prio(l) > slot_prio(p)) big = l;
            if (r < heap_size && slot_prio(r) > slot_prio(big)) big = r;
            if (big == p) break;
            swap_slots(p, big);
            p = big;
        end
    endfunction

    function automatic impq_res_t queue_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                           logic signed [PRIO_W-1:0] req);
        impq_res_t res;
        logic [ID_W-1:0] top, last;
        res = '0;
        if (op == OP_INSERT || op == OP_RAISE || op == OP_LOWER || op == OP_QUERY) begin
            if (id >= id_limit) begin
                res.status = ST_RANGE;
            end else if (op == OP_INSERT) begin
                if (held[id] || heap_size >= CAPACITY) begin
                    res.status = ST_PRESENT;
                end else begin
                    held[id] = 1;
                    prio_of[id] = req;
                    pos_of[id] = heap_size;
                    slot_ids[heap_size] = id;
                    heap_size++;
                    bubble_up(heap_size - 1);
                end
            end else if (!held[id]) begin
                res.status = ST_ABSENT;
            end else if (op == OP_RAISE) begin
                if (prio_of[id] >= req) res.status = ST_DIR;
                else begin
                    prio_of[id] = req;
                    bubble_up(pos_of[id]);
                end
            end else if (op == OP_LOWER) begin
                if (prio_of[id] <= req) res.status = ST_DIR;
                else begin
                    prio_of[id] = req;
                    bubble_down(pos_of[id]);
                end
            end else begin
                res.out_priority = prio_of[id];
            end
        end else if (op == OP_REMOVE) begin
            if (heap_size == 0) begin
                res.status = ST_EMPTY;
            end else begin
                top = slot_ids[0];
                res.out_id = top;
                res.out_priority = prio_of[top];
                held[top] = 0;
                heap_size--;
                if (heap_size > 0) begin
                    last = slot_ids[heap_size];
                    slot_ids[0] = last;
                    pos_of[last] = 0;
                    bubble_down(0);
                end
            end
        end
        res.count = heap_size[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        impq_res_t want, got;
        if (!aresetn) begin
            heap_size = 0;
            id_limit = 7'd64;
            foreach (held[i]) held[i] = 0;
            awaited.delete();
            fail_count <= 0;
            result_total <= 0;
        end else begin
            if (cfg_wr_en) id_limit = cfg_wr_data;
            if (s_tvalid && s_tready)
                awaited.push_back(queue_op(s_tuser, s_tdata[5:0], s_tdata[37:6]));
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.out_id = m_tdata[5:0];
                got.out_priority = m_tdata[37:6];
                got.count = m_tdata[44:38];
                result_total <= result_total + 1;
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = awaited.size();
    end
endmodule

@@ bench/indexed_max_priority_queue_test.sv @@
// Top of the indexed_max_priority_queue bench: clock, reset, stimulus in phases with
// several id limits, random idling on both sides, and the verdict.
// Depends on impq_pkg, indexed_max_priority_queue and its checker.
`timescale 1ns / 1ps
module indexed_max_priority_queue_test;
    import impq_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count, pending, result_total;
    int          cycles = 0;
    bit          calm = 0;
    int          sent = 0;

    always #6 aclk = ~aclk;

    indexed_max_priority_queue dut (.*);
    indexed_max_priority_queue_check checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_tready <= calm || $urandom_range(99) >= 12;
        if (cycles > 400000) begin
            $display("indexed_max_priority_queue_test NOT OK");
            $finish;
        end
    end

    task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                        logic signed [PRIO_W-1:0] pr);
        while (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {2'b0, pr, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain_and_limit(logic [6:0] lim);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic signed [PRIO_W-1:0] rand_prio();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(8) - 4);
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic random_phase(int n, int id_hi);
        int k;
        logic [OP_W-1:0] op;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: op = OP_INSERT;
                6, 7, 8: op = OP_RAISE;
                9, 10, 11: op = OP_LOWER;
                12, 13, 14, 15: op = OP_REMOVE;
                16, 17, 18: op = OP_QUERY;
                default: op = OP_W'($urandom_range(7, 5));
            endcase
            send(op, ID_W'($urandom_range(id_hi)), rand_prio());
        end
    endtask

    initial begin
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        calm = 1;
        send(OP_REMOVE, 0, 0);
        send(OP_QUERY, 5, 0);
        send(OP_RAISE, 5, 1);
        send(OP_INSERT, 63, 32'sh7fffffff);
        send(OP_INSERT, 0, 32'sh80000000);
        send(OP_INSERT, 21, 32'sh00010000);
        send(OP_INSERT, 42, 32'sh00010000);
        send(OP_INSERT, 63, 0);
        send(OP_RAISE, 21, 32'sh00010000);
        send(OP_LOWER, 21, 32'sh00010000);
        send(OP_RAISE, 0, 32'sh7fffffff);
        send(OP_LOWER, 63, 32'sh80000000);
        send(OP_QUERY, 63, 0);
        send(OP_LOWER, 42, 32'sh00020000);
        send(3'd7, 42, 32'shffffffff);
        send(3'd5, 21, 0);
        send(3'd6, 0, 0);
        for (i = 0; i < 5; i++) send(OP_REMOVE, 0, 0);
        calm = 0;
        drain_and_limit(7'd1);
        send(OP_INSERT, 1, 5);
        send(OP_INSERT, 0, 5);
        random_phase(150, 3);
        drain_and_limit(7'd0);
        random_phase(60, 63);
        drain_and_limit(7'd64);
        random_phase(1200, 63);
        calm = 1;
        random_phase(150, 63);
        calm = 0;
        drain_and_limit(7'd13);
        random_phase(250, 20);
        drain_and_limit(7'd127);
        random_phase(150, 63);
        for (i = 0; i < 64; i++) send(OP_REMOVE, 0, 0);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Sent %0d operations over id limits 64, 1, 0, 13 and 127; %0d results checked.",
                 sent, result_total);
        if (fail_count == 0)
            $display("indexed_max_priority_queue_test OK");
        else
            $display("indexed_max_priority_queue_test NOT OK");
        $finish;
    end
endmodule
